### design/dwmd_pkg.sv
package dwmd_pkg;

   localparam int WINDOW_MAX    = 16;
   localparam int POSITION_BITS = 32;
   localparam int SYMBOL_BITS   = 8;
   localparam int WLEN_BITS     = 5;
   localparam int POS_OUT_BITS  = 32;
   localparam int FILL_BITS     = $clog2(WINDOW_MAX + 1);
   localparam int LEN_BITS      = (FILL_BITS > WLEN_BITS) ? FILL_BITS : WLEN_BITS;
   localparam int WLEN_MIN      = 2;

   localparam logic [WLEN_BITS-1:0] WLEN_RESET = WLEN_BITS'(4);

   typedef logic [SYMBOL_BITS-1:0] symbol_type;

   // one record per stream: window (entry 0 newest), counts and the latched marker
   typedef struct packed {
      symbol_type [WINDOW_MAX-1:0] window;
      logic [FILL_BITS-1:0]        fill;
      logic [POSITION_BITS-1:0]    position;
      logic                        found;
      logic [POSITION_BITS-1:0]    found_position;
   } stream_state_type;

   localparam int STATE_BITS  = $bits(stream_state_type);
   localparam int STATE_DEPTH = 1;
   localparam int STATE_ABITS = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;

endpackage

### design/dwmd_if.sv
interface dwmd_req_if import dwmd_pkg::*; ();
   logic       valid;
   logic       ready;
   symbol_type symbol;
   logic       first;

   modport source (output valid, output symbol, output first, input ready);
   modport sink (input valid, input symbol, input first, output ready);
endinterface

interface dwmd_rsp_if import dwmd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    found;
   logic                    found_now;
   logic [POS_OUT_BITS-1:0] marker_position;

   modport source (output valid, output found, output found_now, output marker_position,
                   input ready);
   modport sink (input valid, input found, input found_now, input marker_position,
                 output ready);
endinterface

interface dwmd_csr_if import dwmd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WLEN_BITS-1:0] window_len;

   modport source (output valid, output window_len, input ready);
   modport sink (input valid, input window_len, output ready);
endinterface

### design/dwmd_ram.sv
module dwmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   localparam int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [2**ABITS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/distinct_window_marker_detector.sv
// Start-marker detector: takes one byte symbol per cycle while the response is not stalled and
// reports, for every symbol, whether window_len symbols of the stream in a row have yet all
// been different, latching the 1-based position of the first symbol where that happens. A
// symbol with first set opens a new stream. Throughput is one symbol per clock unless a held
// response stalls it. The symbol is registered at the request transaction; the stream-state
// record read from its RAM is then updated, written back and the result registered once the
// output is free (back-to-back symbols use the forwarded copy). window_len may only be written
// while no transaction is in flight; values below 2 act as 2, above 16 as 16.
module distinct_window_marker_detector import dwmd_pkg::*; (
   input logic         clock,
   input logic         reset,
   dwmd_req_if.sink    req_bus,
   dwmd_rsp_if.source  rsp_bus,
   dwmd_csr_if.sink    csr_bus
);

   logic [WLEN_BITS-1:0]    window_len_ff;
   logic                    s1_valid_ff;
   symbol_type              s1_symbol_ff;
   logic                    s1_first_ff;
   logic                    state_valid_ff;
   logic                    fwd_ff;
   stream_state_type        last_state_ff;
   logic                    rsp_valid_ff;
   logic                    found_ff;
   logic                    found_now_ff;
   logic [POS_OUT_BITS-1:0] marker_position_ff;

   logic                    commit;
   logic                    accept;
   stream_state_type        ram_rdata;
   stream_state_type        cur_state;
   stream_state_type        next_state;
   logic [LEN_BITS-1:0]     wlen;
   logic [LEN_BITS-1:0]     eff_len;
   logic                    distinct;
   logic                    hit;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= WLEN_RESET;
      end else if (csr_bus.valid) begin
         window_len_ff <= csr_bus.window_len;
      end
   end

   assign commit        = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || commit;
   assign accept        = req_bus.valid && req_bus.ready;

   dwmd_ram #(
      .WIDTH (STATE_BITS),
      .DEPTH (STATE_DEPTH)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (STATE_ABITS'(0)),
      .wr_data (next_state),
      .rd_en   (1'b1),
      .rd_addr (STATE_ABITS'(0)),
      .rd_data (ram_rdata)
   );

   // read returns the old record when written in the same cycle, so forward the last write
   always_comb begin
      if (s1_first_ff) begin
         cur_state = '0;
      end else if (fwd_ff) begin
         cur_state = last_state_ff;
      end else if (state_valid_ff) begin
         cur_state = ram_rdata;
      end else begin
         cur_state = '0;
      end
   end

   assign wlen = LEN_BITS'(window_len_ff);

   always_comb begin
      if (wlen < LEN_BITS'(WLEN_MIN)) begin
         eff_len = LEN_BITS'(WLEN_MIN);
      end else if (wlen > LEN_BITS'(WINDOW_MAX)) begin
         eff_len = LEN_BITS'(WINDOW_MAX);
      end else begin
         eff_len = wlen;
      end
   end

   always_comb begin
      next_state        = cur_state;
      next_state.window = {cur_state.window[WINDOW_MAX-2:0], s1_symbol_ff};
      if (cur_state.fill < FILL_BITS'(WINDOW_MAX)) begin
         next_state.fill = cur_state.fill + 1'b1;
      end
      if (cur_state.position != '1) begin
         next_state.position = cur_state.position + 1'b1;
      end

      // all pairs in parallel; the later index limits a pair to the active window
      distinct = 1'b1;
      for (int a = 0; a < WINDOW_MAX - 1; a++) begin
         for (int b = a + 1; b < WINDOW_MAX; b++) begin
            if (LEN_BITS'(b) < eff_len && next_state.window[a] == next_state.window[b]) begin
               distinct = 1'b0;
            end
         end
      end

      hit = !cur_state.found && (LEN_BITS'(next_state.fill) >= eff_len) && distinct;
      if (hit) begin
         next_state.found          = 1'b1;
         next_state.found_position = next_state.position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         state_valid_ff <= 1'b0;
         fwd_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_bus.ready) begin
            s1_valid_ff <= req_bus.valid;
         end
         fwd_ff <= commit;
         if (commit) begin
            state_valid_ff <= 1'b1;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_symbol_ff <= req_bus.symbol;
         s1_first_ff  <= req_bus.first;
      end
      if (commit) begin
         last_state_ff      <= next_state;
         found_ff           <= next_state.found;
         found_now_ff       <= hit;
         marker_position_ff <= next_state.found ?
                               POS_OUT_BITS'(next_state.found_position) : '0;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.found           = found_ff;
   assign rsp_bus.found_now       = found_now_ff;
   assign rsp_bus.marker_position = marker_position_ff;

endmodule

### design/dwmd_checker.sv
module dwmd_checker import dwmd_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic                    found,
   input logic                    found_now,
   input logic [POS_OUT_BITS-1:0] marker_position
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(marker_position) && $stable(found_now))
      else $error("response changed while stalled");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !found |-> !found_now && marker_position == '0)
      else $error("position or found_now reported without a marker");

   a_found_now_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && found_now |-> found && marker_position != '0)
      else $error("new marker without found flag or position");

   // a marker needs at least two symbols of one stream, so two in a row cannot both be new
   a_found_now_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && found_now |=> !(rsp_valid && found_now))
      else $error("found_now on consecutive transactions");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind distinct_window_marker_detector dwmd_checker u_dwmd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .found           (rsp_bus.found),
   .found_now       (rsp_bus.found_now),
   .marker_position (rsp_bus.marker_position)
);
